// File: rtl/aacc_pkg.sv
package aacc_pkg;

   typedef logic [15:0] columns_type;
   typedef logic [1:0] width_type;
   typedef logic [3:0][7:0] char_bytes_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       line_end;
   } rsp_payload_type;

   localparam columns_type MAX_COLUMNS_RESET = 16'd80;
   localparam logic [7:0] ESC_CODE = 8'h1B;
   localparam char_bytes_type SGR_RESET = {8'h6D, 8'h30, 8'h5B, 8'h1B};

endpackage

// File: rtl/aacc_if.sv
interface aacc_req_if;
   import aacc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface aacc_rsp_if;
   import aacc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/aacc_char_width.sv
module aacc_char_width (
   input  aacc_pkg::char_bytes_type char_bytes,
   input  logic [2:0]               have,
   input  logic [2:0]               need,
   output aacc_pkg::width_type      width
);
   import aacc_pkg::*;

   function automatic width_type cp_width(input logic [20:0] cp);
      width_type w;
      w = 2'd1;
      if ((cp >= 21'h1F300 && cp <= 21'h1FAFF) || (cp >= 21'h20000 && cp <= 21'h3FFFD) ||
          (cp >= 21'h1100 && cp <= 21'h115F) || (cp >= 21'h2E80 && cp <= 21'h303E) ||
          (cp >= 21'h3041 && cp <= 21'h33FF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
          (cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'hA000 && cp <= 21'hA4CF) ||
          (cp >= 21'hAC00 && cp <= 21'hD7A3) || (cp >= 21'hF900 && cp <= 21'hFAFF) ||
          (cp >= 21'hFE30 && cp <= 21'hFE4F) || (cp >= 21'hFF00 && cp <= 21'hFF60) ||
          (cp >= 21'hFFE0 && cp <= 21'hFFE6) || (cp >= 21'hE000 && cp <= 21'hF8FF) ||
          (cp >= 21'hF0000 && cp <= 21'hFFFFD) || (cp >= 21'h100000 && cp <= 21'h10FFFD)) begin
         w = 2'd2;
      end
      if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0) ||
          (cp >= 21'h300 && cp <= 21'h36F) || (cp >= 21'h200B && cp <= 21'h200F) ||
          (cp >= 21'hFE00 && cp <= 21'hFE0F) || cp == 21'hFEFF) begin
         w = 2'd0;
      end
      return w;
   endfunction

   logic [20:0] cp;
   logic        trail_ok;
   logic        overlong;

   always_comb begin
      trail_ok = (char_bytes[1][7:6] == 2'b10);
      if (need >= 3'd3) begin
         trail_ok = trail_ok && (char_bytes[2][7:6] == 2'b10);
      end
      if (need == 3'd4) begin
         trail_ok = trail_ok && (char_bytes[3][7:6] == 2'b10);
      end
      case (need)
         3'd2: begin
            cp = {10'd0, char_bytes[0][4:0], char_bytes[1][5:0]};
            overlong = (cp < 21'h80);
         end
         3'd3: begin
            cp = {5'd0, char_bytes[0][3:0], char_bytes[1][5:0], char_bytes[2][5:0]};
            overlong = (cp < 21'h800);
         end
         3'd4: begin
            cp = {char_bytes[0][2:0], char_bytes[1][5:0], char_bytes[2][5:0],
                  char_bytes[3][5:0]};
            overlong = (cp < 21'h10000);
         end
         default: begin
            cp = {13'd0, char_bytes[0]};
            overlong = 1'b0;
         end
      endcase

      if (need == 3'd1) begin
         width = char_bytes[0][7] ? 2'd1 : cp_width(cp);
      end else if (have < need || need > 3'd4 || need == 3'd0 || !trail_ok || overlong ||
                   cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF)) begin
         width = 2'd1;
      end else begin
         width = cp_width(cp);
      end
   end

endmodule

// File: rtl/ansi_aware_column_clipper.sv
// Channel  Direction  Payload                          Handshake
// req_chan in         in_byte, line_last               valid / ready
// rsp_chan out        out_byte, byte_valid, line_end   valid / ready
// csr_*    in         max_columns (16 bits)            write enable only
//
// Each input byte is accepted and its results, up to eight bytes or one end marker,
// are loaded into a burst register that sends one per cycle while rsp_chan is ready.
// A byte with no result loads nothing into the burst register; a byte with n results
// occupies it until all n are sent, and the next byte is taken as the last one leaves.
// Synchronous reset clears the line state and the burst, and sets the budget to 80.
// A stall on rsp_chan holds the burst and, once it is down to one byte, req_chan.
module ansi_aware_column_clipper (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  aacc_pkg::columns_type csr_wr_data,
   aacc_req_if.sink          req_chan,
   aacc_rsp_if.source        rsp_chan
);
   import aacc_pkg::*;

   function automatic logic [2:0] lead_len(input logic [7:0] c);
      logic [2:0] n;
      n = 3'd1;
      if (c[7:5] == 3'b110) n = 3'd2;
      if (c[7:4] == 4'b1110) n = 3'd3;
      if (c[7:3] == 5'b11110) n = 3'd4;
      return n;
   endfunction

   columns_type     max_ff;
   logic [16:0]     cols_ff, cols_in;
   logic            in_esc_ff, in_esc_in;
   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [2:0]      pexp_ff, pexp_in;
   logic            esc_seen_ff, esc_seen_in;
   logic            budget_ff, budget_in;

   logic [7:0][7:0] bb_ff, bb_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            marker_ff, marker_in;
   logic            le_ff, le_in;

   logic [7:0]      b;
   logic            last;
   logic            acc;
   logic            rsp_xfer;
   logic            act_esc, act_pend, act_full, act_escstart, act_char;
   logic [2:0]      len;
   logic [2:0][7:0] pend_upd;
   logic [2:0]      pcnt_upd;
   logic [2:0]      pexp_upd;
   logic            complete;
   logic            fin_en;
   char_bytes_type  fin_bytes;
   logic [2:0]      fin_have;
   logic [2:0]      fin_need;
   width_type       fin_width;
   logic [17:0]     cols_sum;
   logic            fit;
   char_bytes_type  body;
   logic [2:0]      nb;
   logic            sgr;
   logic [3:0]      total;
   logic [7:0][7:0] new_bb;
   logic [2:0]      sgr_idx;

   assign b        = req_chan.payload.in_byte;
   assign last     = req_chan.payload.line_last;
   assign acc      = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = (cnt_ff == 4'd0) || (cnt_ff == 4'd1 && rsp_chan.ready);

   assign rsp_chan.valid              = (cnt_ff != 4'd0);
   assign rsp_chan.payload.out_byte   = bb_ff[0];
   assign rsp_chan.payload.byte_valid = !marker_ff;
   assign rsp_chan.payload.line_end   = le_ff && (cnt_ff == 4'd1);

   always_comb begin
      act_esc      = !budget_ff && in_esc_ff;
      act_pend     = !budget_ff && !in_esc_ff && pexp_ff != 3'd0;
      act_full     = !budget_ff && !in_esc_ff && pexp_ff == 3'd0 &&
                     cols_ff >= {1'b0, max_ff};
      act_escstart = !budget_ff && !in_esc_ff && pexp_ff == 3'd0 && !act_full &&
                     b == ESC_CODE;
      act_char     = !budget_ff && !in_esc_ff && pexp_ff == 3'd0 && !act_full &&
                     b != ESC_CODE;
      len          = lead_len(b);

      pend_upd  = pend_ff;
      pcnt_upd  = {1'b0, pcnt_ff};
      pexp_upd  = pexp_ff;
      complete  = 1'b0;
      fin_en    = 1'b0;
      fin_bytes = '0;
      fin_have  = 3'd0;
      fin_need  = 3'd0;

      if (act_pend) begin
         if (pcnt_ff != 2'd3) begin
            pend_upd[pcnt_ff] = b;
         end
         pcnt_upd = {1'b0, pcnt_ff} + 3'd1;
         complete = (pcnt_upd == pexp_ff);
         if (complete) begin
            fin_bytes          = {8'd0, pend_ff};
            fin_bytes[pcnt_ff] = b;
            fin_en   = 1'b1;
            fin_have = pexp_ff;
            fin_need = pexp_ff;
            pend_upd = '0;
            pcnt_upd = 3'd0;
            pexp_upd = 3'd0;
         end
      end

      if (act_char) begin
         if (len == 3'd1) begin
            fin_en       = 1'b1;
            fin_bytes[0] = b;
            fin_have     = 3'd1;
            fin_need     = 3'd1;
         end else begin
            pend_upd = {8'd0, 8'd0, b};
            pcnt_upd = 3'd1;
            pexp_upd = len;
         end
      end

      // A character cut short by the end of the line is flushed as one column.
      if (last && pexp_upd != 3'd0) begin
         fin_en    = 1'b1;
         fin_bytes = {8'd0, pend_upd};
         fin_have  = pcnt_upd;
         fin_need  = pexp_upd;
      end
   end

   aacc_char_width u_char_width (
      .char_bytes (fin_bytes),
      .have       (fin_have),
      .need       (fin_need),
      .width      (fin_width)
   );

   always_comb begin
      cols_sum    = {1'b0, cols_ff} + {16'd0, fin_width};
      fit         = (cols_sum <= {2'd0, max_ff});

      cols_in     = cols_ff;
      in_esc_in   = in_esc_ff;
      pend_in     = pend_upd;
      pcnt_in     = pcnt_upd[1:0];
      pexp_in     = pexp_upd;
      esc_seen_in = esc_seen_ff || act_escstart;
      budget_in   = budget_ff || act_full;
      body        = '0;
      nb          = 3'd0;

      if (act_esc || act_escstart) begin
         body[0] = b;
         nb      = 3'd1;
      end
      if (act_esc && ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))) begin
         in_esc_in = 1'b0;
      end
      if (act_escstart) begin
         in_esc_in = 1'b1;
      end
      if (fin_en) begin
         if (fit) begin
            body    = fin_bytes;
            nb      = fin_have;
            cols_in = cols_sum[16:0];
         end else begin
            budget_in = 1'b1;
         end
      end

      sgr   = last && esc_seen_in;
      total = {1'b0, nb} + (sgr ? 4'd4 : 4'd0);

      new_bb = '0;
      for (int k = 0; k < 8; k++) begin
         sgr_idx = 3'(k) - nb;
         if (k < int'(nb)) begin
            new_bb[k] = body[2'(k)];
         end else if (sgr && sgr_idx < 3'd4) begin
            new_bb[k] = SGR_RESET[sgr_idx[1:0]];
         end
      end

      if (last) begin
         cols_in     = '0;
         in_esc_in   = 1'b0;
         pend_in     = '0;
         pcnt_in     = 2'd0;
         pexp_in     = 3'd0;
         esc_seen_in = 1'b0;
         budget_in   = 1'b0;
      end

      bb_in     = bb_ff;
      cnt_in    = cnt_ff;
      marker_in = marker_ff;
      le_in     = le_ff;
      if (acc && (total != 4'd0 || last)) begin
         bb_in     = new_bb;
         cnt_in    = (total == 4'd0) ? 4'd1 : total;
         marker_in = (total == 4'd0);
         le_in     = last;
      end else if (rsp_xfer) begin
         for (int k = 0; k < 7; k++) begin
            bb_in[k] = bb_ff[k + 1];
         end
         bb_in[7] = 8'd0;
         cnt_in   = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff      <= MAX_COLUMNS_RESET;
         cols_ff     <= '0;
         in_esc_ff   <= 1'b0;
         pend_ff     <= '0;
         pcnt_ff     <= 2'd0;
         pexp_ff     <= 3'd0;
         esc_seen_ff <= 1'b0;
         budget_ff   <= 1'b0;
         cnt_ff      <= 4'd0;
         marker_ff   <= 1'b0;
         le_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (acc) begin
            cols_ff     <= cols_in;
            in_esc_ff   <= in_esc_in;
            pend_ff     <= pend_in;
            pcnt_ff     <= pcnt_in;
            pexp_ff     <= pexp_in;
            esc_seen_ff <= esc_seen_in;
            budget_ff   <= budget_in;
         end
         cnt_ff    <= cnt_in;
         marker_ff <= marker_in;
         le_ff     <= le_in;
      end
   end

   always_ff @(posedge clock) begin
      bb_ff <= bb_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'd8)
      else $error("burst register holds more than eight bytes");

   assert property (@(posedge clock) disable iff (reset)
      acc |-> (cnt_ff == 4'd0 || (cnt_ff == 4'd1 && rsp_xfer)))
      else $error("transfer accepted while the burst still has bytes to send");

   assert property (@(posedge clock) disable iff (reset)
      !(budget_ff && in_esc_ff))
      else $error("budget reached inside an escape sequence");

   assert property (@(posedge clock) disable iff (reset)
      pexp_ff != 3'd0 |-> ({1'b0, pcnt_ff} < pexp_ff && !budget_ff && !in_esc_ff))
      else $error("partial character state is inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      (marker_ff && cnt_ff != 4'd0) |-> (cnt_ff == 4'd1 && le_ff))
      else $error("end marker is not a single line-end transfer");
`endif

endmodule

// File: dv/tb_ansi_aware_column_clipper.sv
`timescale 1ns / 1ps

module tb_ansi_aware_column_clipper;
   import aacc_pkg::*;

   typedef struct packed {
      req_payload_type item;
      logic            hold;
   } send_entry_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   columns_type csr_wr_data;

   aacc_req_if req_if ();
   aacc_rsp_if rsp_if ();

   ansi_aware_column_clipper uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   send_entry_type  send_queue[$];
   rsp_payload_type clipped_bytes[$];
   logic [7:0]      line_bytes[$];

   int send_gap_max = 0;
   int recv_gap_max = 0;
   int send_wait;
   int recv_wait;
   int items_sent = 0;
   int items_taken = 0;
   int results_seen = 0;
   int fail_count = 0;

   columns_type    budget;
   logic [16:0]    line_columns;
   logic           in_sequence;
   logic           sequence_passed;
   logic           line_full;
   char_bytes_type held_char;
   logic [2:0]     held_need;
   logic [2:0]     held_have;
   int             step_results;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void restart_line();
      line_columns = '0;
      in_sequence = 1'b0;
      sequence_passed = 1'b0;
      line_full = 1'b0;
      held_char = '0;
      held_need = '0;
      held_have = '0;
   endfunction

   function automatic logic [1:0] glyph_columns(logic [31:0] cp);
      if (cp < 32'h20 || (cp >= 32'h7F && cp < 32'hA0)) return 2'd0;
      if ((cp >= 32'h300 && cp <= 32'h36F) || (cp >= 32'h200B && cp <= 32'h200F) ||
          (cp >= 32'hFE00 && cp <= 32'hFE0F) || cp == 32'hFEFF)
         return 2'd0;
      if ((cp >= 32'h1100 && cp <= 32'h115F) || (cp >= 32'h2E80 && cp <= 32'h303E) ||
          (cp >= 32'h3041 && cp <= 32'h33FF) || (cp >= 32'h3400 && cp <= 32'h4DBF) ||
          (cp >= 32'h4E00 && cp <= 32'h9FFF) || (cp >= 32'hA000 && cp <= 32'hA4CF) ||
          (cp >= 32'hAC00 && cp <= 32'hD7A3) || (cp >= 32'hF900 && cp <= 32'hFAFF) ||
          (cp >= 32'hFE30 && cp <= 32'hFE4F) || (cp >= 32'hFF00 && cp <= 32'hFF60) ||
          (cp >= 32'hFFE0 && cp <= 32'hFFE6) || (cp >= 32'h1F300 && cp <= 32'h1FAFF) ||
          (cp >= 32'h20000 && cp <= 32'h3FFFD))
         return 2'd2;
      if ((cp >= 32'hE000 && cp <= 32'hF8FF) || (cp >= 32'hF0000 && cp <= 32'hFFFFD) ||
          (cp >= 32'h100000 && cp <= 32'h10FFFD))
         return 2'd2;
      return 2'd1;
   endfunction

   function automatic logic [2:0] utf8_length(logic [7:0] b);
      if (b[7] == 1'b0) return 3'd1;
      if (b[7:5] == 3'b110) return 3'd2;
      if (b[7:4] == 4'b1110) return 3'd3;
      if (b[7:3] == 5'b11110) return 3'd4;
      return 3'd1;
   endfunction

   function automatic logic [1:0] char_columns(char_bytes_type b, logic [2:0] have,
                                               logic [2:0] need);
      logic [31:0] cp;
      int          k;
      if (need == 3'd1) return (b[0] < 8'h80) ? glyph_columns({24'd0, b[0]}) : 2'd1;
      if (have < need) return 2'd1;
      case (need)
         3'd2: cp = {27'd0, b[0][4:0]};
         3'd3: cp = {28'd0, b[0][3:0]};
         default: cp = {29'd0, b[0][2:0]};
      endcase
      for (k = 1; k < need; k++) begin
         if (b[k][7:6] != 2'b10) return 2'd1;
         cp = (cp << 6) | {26'd0, b[k][5:0]};
      end
      if (need == 3'd2 && cp < 32'h80) return 2'd1;
      if (need == 3'd3 && cp < 32'h800) return 2'd1;
      if (need == 3'd4 && cp < 32'h10000) return 2'd1;
      if (cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF)) return 2'd1;
      return glyph_columns(cp);
   endfunction

   function automatic void emit_byte(logic [7:0] v);
      rsp_payload_type r;
      r.out_byte = v;
      r.byte_valid = 1'b1;
      r.line_end = 1'b0;
      clipped_bytes.insert(clipped_bytes.size(), r);
      step_results++;
   endfunction

   function automatic void place_char(char_bytes_type b, logic [2:0] have, logic [2:0] need);
      logic [1:0] w;
      int         k;
      w = char_columns(b, have, need);
      if (line_columns + w > budget) begin
         line_full = 1'b1;
         return;
      end
      for (k = 0; k < have; k++) emit_byte(b[k]);
      line_columns = line_columns + w;
   endfunction

   function automatic void clip_byte(req_payload_type item);
      logic [7:0]      b;
      char_bytes_type  single;
      rsp_payload_type r;
      int              k;
      b = item.in_byte;
      step_results = 0;
      if (!line_full) begin
         if (in_sequence) begin
            emit_byte(b);
            if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) in_sequence = 1'b0;
         end else if (held_need != 3'd0) begin
            held_char[held_have[1:0]] = b;
            held_have = held_have + 3'd1;
            if (held_have >= held_need) begin
               place_char(held_char, held_have, held_need);
               held_char = '0;
               held_have = '0;
               held_need = '0;
            end
         end else if (line_columns >= budget) begin
            line_full = 1'b1;
         end else if (b == ESC_CODE) begin
            emit_byte(b);
            in_sequence = 1'b1;
            sequence_passed = 1'b1;
         end else if (utf8_length(b) == 3'd1) begin
            single = '0;
            single[0] = b;
            place_char(single, 3'd1, 3'd1);
         end else begin
            held_char = '0;
            held_char[0] = b;
            held_have = 3'd1;
            held_need = utf8_length(b);
         end
      end
      if (item.line_last) begin
         if (held_need != 3'd0 && !line_full) place_char(held_char, held_have, held_need);
         if (sequence_passed) begin
            for (k = 0; k < 4; k++) emit_byte(SGR_RESET[k]);
         end
         if (step_results == 0) begin
            r.out_byte = 8'd0;
            r.byte_valid = 1'b0;
            r.line_end = 1'b1;
         end else begin
            r = clipped_bytes.pop_back();
            r.line_end = 1'b1;
         end
         clipped_bytes.insert(clipped_bytes.size(), r);
         restart_line();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            clip_byte(req_if.payload);
            items_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (send_queue.size() != 0 &&
                         !(send_queue[0].hold && clipped_bytes.size() != 0)) begin
               req_if.payload <= send_queue[0].item;
               req_if.valid <= 1'b1;
               void'(send_queue.pop_front());
               send_wait = $urandom_range(0, send_gap_max);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(string what);
      fail_count++;
      if (fail_count <= 40) $display("mismatch: %s", what);
   endtask

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (clipped_bytes.size() == 0) begin
               report_mismatch($sformatf("transfer %0d unexpected: byte %h valid %b end %b",
                                         results_seen, got.out_byte, got.byte_valid,
                                         got.line_end));
            end else begin
               want = clipped_bytes.pop_front();
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.line_end !== want.line_end)
                  report_mismatch($sformatf(
                     "transfer %0d: byte %h valid %b end %b, wanted %h %b %b", results_seen,
                     got.out_byte, got.byte_valid, got.line_end, want.out_byte,
                     want.byte_valid, want.line_end));
            end
            results_seen++;
            recv_wait = $urandom_range(0, recv_gap_max);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic queue_byte(logic [7:0] b, logic last, logic hold);
      send_entry_type e;
      e.item.in_byte = b;
      e.item.line_last = last;
      e.hold = hold;
      send_queue.insert(send_queue.size(), e);
      items_sent++;
   endtask

   task automatic flush_line(logic last, logic hold);
      int k;
      for (k = 0; k < line_bytes.size(); k++)
         queue_byte(line_bytes[k], last && k == line_bytes.size() - 1, hold && k == 0);
      line_bytes.delete();
   endtask

   task automatic drain();
      while (items_taken != items_sent || clipped_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_budget(columns_type value);
      drain();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      budget = value;
   endtask

   function automatic void add_byte(logic [7:0] v);
      line_bytes.insert(line_bytes.size(), v);
   endfunction

   task automatic add_code_point(logic cut);
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] cp;
      logic [7:0]  glyph[$];
      case ($urandom_range(0, 26))
         0: begin lo = 32'h20; hi = 32'h7E; end
         1: begin lo = 32'h0; hi = 32'h1F; end
         2: begin lo = 32'h7F; hi = 32'h9F; end
         3: begin lo = 32'hA0; hi = 32'h7FF; end
         4: begin lo = 32'h300; hi = 32'h36F; end
         5: begin lo = 32'h1100; hi = 32'h115F; end
         6: begin lo = 32'h200B; hi = 32'h200F; end
         7: begin lo = 32'h2E80; hi = 32'h303E; end
         8: begin lo = 32'h3041; hi = 32'h33FF; end
         9: begin lo = 32'h3400; hi = 32'h4DBF; end
         10: begin lo = 32'h4E00; hi = 32'h9FFF; end
         11: begin lo = 32'hA000; hi = 32'hA4CF; end
         12: begin lo = 32'hAC00; hi = 32'hD7A3; end
         13: begin lo = 32'hD800; hi = 32'hDFFF; end
         14: begin lo = 32'hE000; hi = 32'hF8FF; end
         15: begin lo = 32'hF900; hi = 32'hFAFF; end
         16: begin lo = 32'hFE00; hi = 32'hFE0F; end
         17: begin lo = 32'hFE30; hi = 32'hFE4F; end
         18: begin lo = 32'hFEFF; hi = 32'hFEFF; end
         19: begin lo = 32'hFF00; hi = 32'hFF60; end
         20: begin lo = 32'hFFE0; hi = 32'hFFE6; end
         21: begin lo = 32'h1F300; hi = 32'h1FAFF; end
         22: begin lo = 32'h20000; hi = 32'h3FFFD; end
         23: begin lo = 32'hF0000; hi = 32'hFFFFD; end
         24: begin lo = 32'h100000; hi = 32'h10FFFF; end
         25: begin lo = 32'h800; hi = 32'hFFFF; end
         default: begin lo = 32'h10000; hi = 32'h10FFFF; end
      endcase
      case ($urandom_range(0, 7))
         0: cp = (lo == 32'h0) ? lo : lo - 32'd1;
         1: cp = lo;
         2: cp = hi;
         3: cp = hi + 32'd1;
         default: cp = $urandom_range(lo, hi);
      endcase
      if (cp < 32'h80) begin
         glyph.insert(glyph.size(), cp[7:0]);
      end else if (cp < 32'h800) begin
         glyph.insert(glyph.size(), {3'b110, cp[10:6]});
         glyph.insert(glyph.size(), {2'b10, cp[5:0]});
      end else if (cp < 32'h10000) begin
         glyph.insert(glyph.size(), {4'b1110, cp[15:12]});
         glyph.insert(glyph.size(), {2'b10, cp[11:6]});
         glyph.insert(glyph.size(), {2'b10, cp[5:0]});
      end else begin
         glyph.insert(glyph.size(), {5'b11110, cp[20:18]});
         glyph.insert(glyph.size(), {2'b10, cp[17:12]});
         glyph.insert(glyph.size(), {2'b10, cp[11:6]});
         glyph.insert(glyph.size(), {2'b10, cp[5:0]});
      end
      if (cut && glyph.size() > 1) void'(glyph.pop_back());
      foreach (glyph[k]) add_byte(glyph[k]);
   endtask

   task automatic add_random_line(int unsigned chars, logic last);
      logic [7:0] v;
      repeat (chars) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: add_byte(8'($urandom_range(8'h20, 8'h7E)));
            6: add_byte(8'($urandom_range(8'h00, 8'h1F)));
            7, 8, 9, 10: add_code_point(1'b0);
            11: begin
               add_byte(ESC_CODE);
               add_byte("[");
               repeat ($urandom_range(0, 3)) begin
                  v = ($urandom_range(0, 3) == 0) ? ";" : 8'("0" + $urandom_range(0, 9));
                  add_byte(v);
               end
               v = ($urandom_range(0, 1) == 0) ? 8'("A" + $urandom_range(0, 25))
                                               : 8'("a" + $urandom_range(0, 25));
               add_byte(v);
            end
            12: begin
               repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
            end
            13: begin
               v = 8'($urandom_range(0, 8'h7F));
               add_byte({3'b110, 4'b0000, v[6]});
               add_byte({2'b10, v[5:0]});
            end
            14: add_code_point(1'b1);
            default: begin
               if ($urandom_range(0, 1) == 0)
                  add_byte(8'($urandom_range(8'h80, 8'hBF)));
               else
                  add_byte(8'($urandom_range(8'hF8, 8'hFF)));
            end
         endcase
      end
      flush_line(last, $urandom_range(0, 7) == 0);
   endtask

   initial begin
      int phase;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      budget = MAX_COLUMNS_RESET;
      restart_line();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_gap_max = 18;
      recv_gap_max = 18;
      line_bytes = '{ESC_CODE, 8'h5B, 8'h6D, 8'h41, 8'hE4, 8'hB8, 8'h80, 8'hCC, 8'h80,
                     8'h00, 8'hFF, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                     8'hF0, 8'h9F, 8'h8C, 8'h80, 8'hC3, 8'h41, 8'hE4, 8'hB8};
      flush_line(1'b1, 1'b1);

      write_budget(16'd0);
      send_gap_max = 0;
      recv_gap_max = 0;
      line_bytes = '{8'h62};
      flush_line(1'b1, 1'b0);

      write_budget(16'd3);
      line_bytes = '{8'h78, 8'h79};
      flush_line(1'b0, 1'b0);
      write_budget(16'd4);
      line_bytes = '{8'hE4, 8'hB8, 8'h80, 8'h71};
      flush_line(1'b1, 1'b0);

      phase = 0;
      while (items_sent < 110) begin
         case (phase)
            0: write_budget(16'd0);
            1: write_budget(16'hFFFF);
            default: begin
               case ($urandom_range(0, 5))
                  0, 1, 2: write_budget(columns_type'($urandom_range(1, 12)));
                  3: write_budget(MAX_COLUMNS_RESET);
                  4: write_budget(columns_type'($urandom_range(0, 16'hFFFF)));
                  default: write_budget(16'd2);
               endcase
            end
         endcase
         case (phase % 5)
            0: begin send_gap_max = 18; recv_gap_max = 18; end
            1: begin send_gap_max = 0; recv_gap_max = 0; end
            2: begin send_gap_max = 0; recv_gap_max = 18; end
            3: begin send_gap_max = 18; recv_gap_max = 0; end
            default: begin send_gap_max = 3; recv_gap_max = 3; end
         endcase
         repeat ($urandom_range(2, 4)) add_random_line($urandom_range(1, 10), 1'b1);
         if ($urandom_range(0, 4) == 0) add_random_line($urandom_range(1, 4), 1'b0);
         phase++;
      end
      add_random_line(1, 1'b1);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && clipped_bytes.size() == 0) begin
         $display("PASS ansi_aware_column_clipper");
      end else begin
         $display("FAIL ansi_aware_column_clipper");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL ansi_aware_column_clipper");
      $finish;
   end

endmodule
